@@ design/sdkc_pkg.sv @@
// Shared types and constants for the scanned display key classifier.
`timescale 1ns / 1ps

package sdkc_pkg;

  localparam int unsigned GlyphW   = 5;
  localparam int unsigned PointW   = 2;
  localparam int unsigned ThreshW  = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned KeyW     = 3;
  localparam int unsigned KeyIdW   = 2;

  localparam logic [GlyphW-1:0] BlankGlyph = GlyphW'(10);

  localparam logic [PhaseW-1:0] PhaseLeft   = 2'd0;
  localparam logic [PhaseW-1:0] PhaseCenter = 2'd1;
  localparam logic [PhaseW-1:0] PhaseRight  = 2'd2;

  localparam logic [KeyW-1:0] KeyNone = 3'd0;
  localparam logic [KeyW-1:0] KeyDown = 3'd4;

  localparam logic [PointW-1:0] PointReset  = 2'd0;
  localparam logic [ThreshW-1:0] ShortReset = 16'd2;
  localparam logic [ThreshW-1:0] LongReset  = 16'd200;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_POLL = 1'b1
  } sdkc_op_e;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_PRESSING      = 3'd1,
    EV_SHORT_RELEASE = 3'd2,
    EV_LONG_HOLD     = 3'd3,
    EV_LONG_RELEASE  = 3'd4
  } sdkc_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GLYPH_LEFT      = 3'd0,
    REG_GLYPH_CENTER    = 3'd1,
    REG_GLYPH_RIGHT     = 3'd2,
    REG_POINT_POSITION  = 3'd3,
    REG_SHORT_THRESHOLD = 3'd4,
    REG_LONG_THRESHOLD  = 3'd5
  } sdkc_reg_e;

endpackage

@@ design/scanned_display_key_classifier_unit.sv @@
// Top level of the scanned display driver and key classifier.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+---------------------------------
//   in       | input     | in_valid_i / in_ready_o | operation, sense_line, extra_key
//   out      | output    | out_valid_o/out_ready_i | digit_select, glyph, point_on,
//            |           |                         | press_event, key_id
//   cfg      | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// State updates at the accepting edge and the
// result register holds the answer the cycle after.
// One transaction per cycle is sustained while the output side takes results.
// The output register frees in the same cycle it is taken, so a stalled
// output holds the input side only while the result register is full.
// Reset clears phase, key state, counter and valid, and loads config defaults.
`timescale 1ns / 1ps

module scanned_display_key_classifier_unit #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic                          sense_line_i,
  input  logic                          extra_key_line_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sdkc_pkg::PhaseW-1:0]   digit_select_o,
  output logic [sdkc_pkg::GlyphW-1:0]   glyph_o,
  output logic                          point_on_o,
  output logic [2:0]                    press_event_o,
  output logic [sdkc_pkg::KeyIdW-1:0]   key_id_o,
  input  logic                          cfg_we_i,
  input  logic [sdkc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sdkc_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CmpW = (COUNT_BITS > sdkc_pkg::ThreshW) ? COUNT_BITS
                                                                  : sdkc_pkg::ThreshW;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [sdkc_pkg::GlyphW-1:0]  glyph_left_q, glyph_center_q, glyph_right_q;
  logic [sdkc_pkg::PointW-1:0]  point_pos_q;
  logic [sdkc_pkg::ThreshW-1:0] short_thr_q, long_thr_q;

  logic [sdkc_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [sdkc_pkg::KeyW-1:0]   held_q, held_d;
  logic [sdkc_pkg::KeyW-1:0]   rel_q, rel_d;
  logic [COUNT_BITS-1:0]       count_q, count_d, count_inc;

  logic                         out_valid_q;
  logic [sdkc_pkg::PhaseW-1:0]  sel_q, sel_d;
  logic [sdkc_pkg::GlyphW-1:0]  glyph_q, glyph_d;
  logic                         point_q, point_d;
  sdkc_pkg::sdkc_event_e        event_q, event_d;
  logic [sdkc_pkg::KeyIdW-1:0]  key_q, key_d;

  logic                        in_fire;
  logic [sdkc_pkg::KeyW-1:0]   phase_key;
  logic [CmpW-1:0]             count_cmp, short_cmp, long_cmp;
  logic                        over_long, over_short;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign phase_key = sdkc_pkg::KeyW'(phase_q) + sdkc_pkg::KeyW'(1);
  assign count_inc = (count_q == CountMax) ? count_q : count_q + COUNT_BITS'(1);

  assign short_cmp  = CmpW'(short_thr_q);
  assign long_cmp   = CmpW'(long_thr_q);

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    rel_d      = rel_q;
    count_d    = count_q;
    event_d    = sdkc_pkg::EV_NONE;
    key_d      = '0;
    count_cmp  = '0;
    over_long  = 1'b0;
    over_short = 1'b0;
    if (sdkc_pkg::sdkc_op_e'(operation_i) == sdkc_pkg::OP_SCAN) begin
      phase_d = (phase_q == sdkc_pkg::PhaseRight || phase_q > sdkc_pkg::PhaseRight)
                ? sdkc_pkg::PhaseLeft : phase_q + sdkc_pkg::PhaseW'(1);
    end else begin
      if (!sense_line_i) begin
        if (phase_q != 2'd3) begin
          held_d = phase_key;
        end
        count_d = count_inc;
      end else if (extra_key_line_i) begin
        held_d  = sdkc_pkg::KeyDown;
        count_d = count_inc;
      end else if (held_q != sdkc_pkg::KeyNone) begin
        if ((held_q < sdkc_pkg::KeyDown && held_q == phase_key) ||
            held_q == sdkc_pkg::KeyDown) begin
          rel_d  = held_q;
          held_d = sdkc_pkg::KeyNone;
        end else begin
          count_d = count_inc;
        end
      end

      count_cmp  = CmpW'(count_d);
      over_long  = count_cmp > long_cmp;
      over_short = count_cmp > short_cmp;

      if (held_d != sdkc_pkg::KeyNone && over_long) begin
        event_d = sdkc_pkg::EV_LONG_HOLD;
        key_d   = sdkc_pkg::KeyIdW'(held_d - sdkc_pkg::KeyW'(1));
      end else if (held_d == sdkc_pkg::KeyNone && rel_d != sdkc_pkg::KeyNone &&
                   over_long) begin
        event_d = sdkc_pkg::EV_LONG_RELEASE;
        key_d   = sdkc_pkg::KeyIdW'(rel_d - sdkc_pkg::KeyW'(1));
        count_d = '0;
        rel_d   = sdkc_pkg::KeyNone;
      end else if (held_d == sdkc_pkg::KeyNone && rel_d != sdkc_pkg::KeyNone &&
                   over_short) begin
        event_d = sdkc_pkg::EV_SHORT_RELEASE;
        key_d   = sdkc_pkg::KeyIdW'(rel_d - sdkc_pkg::KeyW'(1));
        count_d = '0;
        rel_d   = sdkc_pkg::KeyNone;
      end else if (held_d != sdkc_pkg::KeyNone) begin
        event_d = sdkc_pkg::EV_PRESSING;
        key_d   = sdkc_pkg::KeyIdW'(held_d - sdkc_pkg::KeyW'(1));
      end else begin
        count_d = '0;
        rel_d   = sdkc_pkg::KeyNone;
      end
    end
  end

  always_comb begin
    sel_d = phase_d;
    case (phase_d)
      sdkc_pkg::PhaseLeft:   glyph_d = glyph_left_q;
      sdkc_pkg::PhaseCenter: glyph_d = glyph_center_q;
      sdkc_pkg::PhaseRight:  glyph_d = glyph_right_q;
      default:               glyph_d = sdkc_pkg::BlankGlyph;
    endcase
    point_d = (phase_d != 2'd3) &&
              (sdkc_pkg::KeyW'(point_pos_q) ==
               sdkc_pkg::KeyW'(phase_d) + sdkc_pkg::KeyW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_left_q   <= sdkc_pkg::BlankGlyph;
      glyph_center_q <= sdkc_pkg::BlankGlyph;
      glyph_right_q  <= sdkc_pkg::BlankGlyph;
      point_pos_q    <= sdkc_pkg::PointReset;
      short_thr_q    <= sdkc_pkg::ShortReset;
      long_thr_q     <= sdkc_pkg::LongReset;
    end else if (cfg_we_i) begin
      case (sdkc_pkg::sdkc_reg_e'(cfg_index_i))
        sdkc_pkg::REG_GLYPH_LEFT:      glyph_left_q   <= cfg_data_i[sdkc_pkg::GlyphW-1:0];
        sdkc_pkg::REG_GLYPH_CENTER:    glyph_center_q <= cfg_data_i[sdkc_pkg::GlyphW-1:0];
        sdkc_pkg::REG_GLYPH_RIGHT:     glyph_right_q  <= cfg_data_i[sdkc_pkg::GlyphW-1:0];
        sdkc_pkg::REG_POINT_POSITION:  point_pos_q    <= cfg_data_i[sdkc_pkg::PointW-1:0];
        sdkc_pkg::REG_SHORT_THRESHOLD: short_thr_q    <= cfg_data_i[sdkc_pkg::ThreshW-1:0];
        sdkc_pkg::REG_LONG_THRESHOLD:  long_thr_q     <= cfg_data_i[sdkc_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sdkc_pkg::PhaseLeft;
      held_q      <= sdkc_pkg::KeyNone;
      rel_q       <= sdkc_pkg::KeyNone;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        rel_q   <= rel_d;
        count_q <= count_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sel_q   <= sel_d;
      glyph_q <= glyph_d;
      point_q <= point_d;
      event_q <= event_d;
      key_q   <= key_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_select_o = sel_q;
  assign glyph_o        = glyph_q;
  assign point_on_o     = point_q;
  assign press_event_o  = event_q;
  assign key_id_o       = key_q;

endmodule
